[sv/stl_pkg.sv]
`timescale 1ns / 1ps

package stl_pkg;

	typedef enum logic [3:0] {
		M_IDLE,
		M_IDENT,
		M_NUMBER,
		M_NUMDOT,
		M_STRING,
		M_COMMENT,
		M_SLASH,
		M_DOT1,
		M_DOT2,
		M_OP1
	} lex_mode_t;

	localparam int KIND_W = 6;
	localparam int LINE_W = 24;

endpackage

[sv/stl_outq.sv]
`timescale 1ns / 1ps

module stl_outq #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push0,
	input  logic         push1,
	input  logic [W-1:0] data0,
	input  logic [W-1:0] data1,
	input  logic         pop,
	output logic [W-1:0] head,
	output logic         not_empty,
	output logic         room2
);

	logic [W-1:0] mem_q [4];
	logic [1:0]   wp_q;
	logic [1:0]   rp_q;
	logic [2:0]   cnt_q;

	assign head      = mem_q[rp_q];
	assign not_empty = cnt_q != 3'd0;
	assign room2     = cnt_q <= 3'd2;

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wp_q] <= data0;
		end
		if (push1) begin
			mem_q[wp_q + 2'd1] <= data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 2'd0;
			rp_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wp_q  <= wp_q + 2'(push0) + 2'(push1);
			rp_q  <= rp_q + 2'(pop);
			cnt_q <= cnt_q + 3'(push0) + 3'(push1) - 3'(pop);
		end
	end

endmodule

[sv/stl_core.sv]
`timescale 1ns / 1ps

module stl_core #(
	parameter int OFFSET_BITS = 32,
	parameter int LENGTH_BITS = 16,
	localparam int RW = 1 + stl_pkg::LINE_W + LENGTH_BITS + OFFSET_BITS + stl_pkg::KIND_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_acc,
	input  logic [7:0]                  in_byte,
	input  logic                        cfg_we,
	input  logic [stl_pkg::LINE_W-1:0]  cfg_data,
	output logic                        push0,
	output logic                        push1,
	output logic [RW-1:0]               res0,
	output logic [RW-1:0]               res1
);

	localparam int OB = OFFSET_BITS;
	localparam int LB = LENGTH_BITS;
	localparam int LW = stl_pkg::LINE_W;
	localparam int KW = stl_pkg::KIND_W;

	localparam logic [KW-1:0] K_END = 6'd0, K_BAD = 6'd1, K_IDENT = 6'd2, K_INT = 6'd3;
	localparam logic [KW-1:0] K_FLOAT = 6'd4, K_STR = 6'd5, K_XX = 6'd6, K_DOT3 = 6'd7;
	localparam logic [KW-1:0] K_OROR = 6'd8, K_EQEQ = 6'd9, K_NE = 6'd10, K_ANDAND = 6'd11;
	localparam logic [KW-1:0] K_MULEQ = 6'd12, K_DIVEQ = 6'd13, K_ADDEQ = 6'd14;
	localparam logic [KW-1:0] K_SUBEQ = 6'd15, K_GE = 6'd16, K_LE = 6'd17, K_DOT2 = 6'd18;
	localparam logic [KW-1:0] K_LBRACE = 6'd19, K_RBRACE = 6'd20, K_LBRACK = 6'd21;
	localparam logic [KW-1:0] K_RBRACK = 6'd22, K_LPAREN = 6'd23, K_RPAREN = 6'd24;
	localparam logic [KW-1:0] K_SEMI = 6'd25, K_COLON = 6'd26, K_COMMA = 6'd27;
	localparam logic [KW-1:0] K_NOT = 6'd28, K_AND = 6'd29, K_HASH = 6'd30, K_ADD = 6'd31;
	localparam logic [KW-1:0] K_DOT = 6'd32, K_ASSIGN = 6'd33, K_SUB = 6'd34;
	localparam logic [KW-1:0] K_MUL = 6'd35, K_DIV = 6'd36, K_MOD = 6'd37;
	localparam logic [KW-1:0] K_GT = 6'd38, K_LT = 6'd39;

	localparam logic [7:0] C_X = 8'h78, C_QUOTE = 8'h22, C_UNDER = 8'h5F, C_DOT = 8'h2E;
	localparam logic [7:0] C_HASH = 8'h23, C_PCT = 8'h25, C_NUL = 8'h00, C_SP = 8'h20;
	localparam logic [7:0] C_TAB = 8'h09, C_CR = 8'h0D, C_LF = 8'h0A, C_SLASH = 8'h2F;
	localparam logic [7:0] C_BSL = 8'h5C, C_BAR = 8'h7C, C_EQ = 8'h3D, C_BANG = 8'h21;
	localparam logic [7:0] C_AMP = 8'h26, C_STAR = 8'h2A, C_PLUS = 8'h2B, C_MINUS = 8'h2D;
	localparam logic [7:0] C_GT = 8'h3E, C_LT = 8'h3C, C_LBRACE = 8'h7B, C_RBRACE = 8'h7D;
	localparam logic [7:0] C_LBRACK = 8'h5B, C_RBRACK = 8'h5D, C_LPAREN = 8'h28;
	localparam logic [7:0] C_RPAREN = 8'h29, C_SEMI = 8'h3B, C_COLON = 8'h3A, C_COMMA = 8'h2C;

	localparam logic [LB-1:0] LEN_MAX = '1;

	function automatic logic is_digit(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic id_first(input logic [7:0] b);
		return b == C_UNDER || (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
	endfunction

	function automatic logic [LB-1:0] sat_add(input logic [LB-1:0] v, input logic [1:0] n);
		logic [LB:0] s;
		s = {1'b0, v} + (LB+1)'(n);
		return s[LB] ? LEN_MAX : s[LB-1:0];
	endfunction

	function automatic logic [KW-1:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
		logic [KW-1:0] k;
		k = K_END;
		if (p == C_BAR && c == C_BAR) begin
			k = K_OROR;
		end else if (p == C_AMP && c == C_AMP) begin
			k = K_ANDAND;
		end else if (c == C_EQ) begin
			unique case (p)
				C_EQ:    k = K_EQEQ;
				C_BANG:  k = K_NE;
				C_STAR:  k = K_MULEQ;
				C_PLUS:  k = K_ADDEQ;
				C_MINUS: k = K_SUBEQ;
				C_GT:    k = K_GE;
				C_LT:    k = K_LE;
				default: k = K_END;
			endcase
		end
		return k;
	endfunction

	function automatic logic [KW-1:0] single_kind(input logic [7:0] p);
		logic [KW-1:0] k;
		unique case (p)
			C_BANG:  k = K_NOT;
			C_AMP:   k = K_AND;
			C_PLUS:  k = K_ADD;
			C_EQ:    k = K_ASSIGN;
			C_MINUS: k = K_SUB;
			C_STAR:  k = K_MUL;
			C_GT:    k = K_GT;
			C_LT:    k = K_LT;
			default: k = K_BAD;
		endcase
		return k;
	endfunction

	stl_pkg::lex_mode_t mode_q, mode_n;
	logic [7:0]    h0_q, h1_q, h0_n, h1_n;
	logic [1:0]    hc_q, hc_n;
	logic [OB-1:0] off_q, off_n, tb_q, tb_n;
	logic [LB-1:0] len_q, len_n;
	logic [LW-1:0] line_q, line_n, tbl_q, tbl_n, start_q;
	logic          frac_q, frac_n, bs_q, bs_n;

	logic          again, ended;
	logic          av, iv;
	logic [KW-1:0] ak, ik;
	logic [OB-1:0] ao, io;
	logic [LB-1:0] al, il;
	logic [LW-1:0] aln, iln;
	logic [KW-1:0] pk, sk;
	logic [7:0]    c;

	assign c = in_byte;

	always_comb begin
		mode_n = mode_q;
		h0_n = h0_q; h1_n = h1_q; hc_n = hc_q;
		tb_n = tb_q; len_n = len_q; line_n = line_q; tbl_n = tbl_q;
		frac_n = frac_q; bs_n = bs_q;
		again = 1'b0; ended = 1'b0;
		av = 1'b0; ak = K_END; ao = tb_q; al = len_q; aln = tbl_q;
		iv = 1'b0; ik = K_END; io = off_q; il = LB'(1); iln = line_q;
		pk = pair_kind(h0_q, c);
		sk = single_kind(h0_q);

		unique case (mode_q)
			stl_pkg::M_IDENT: begin
				if (id_first(c) || is_digit(c)) begin
					len_n = sat_add(len_q, 2'd1);
					if (hc_q < 2'd2) begin
						if (hc_q[0]) begin
							h1_n = c;
						end else begin
							h0_n = c;
						end
						hc_n = hc_q + 2'd1;
					end
				end else begin
					av = 1'b1;
					ak = (len_q == LB'(2) && hc_q == 2'd2 && h0_q == C_X && h1_q == C_X)
						? K_XX : K_IDENT;
					mode_n = stl_pkg::M_IDLE;
					again = 1'b1;
				end
			end
			stl_pkg::M_NUMBER: begin
				if (is_digit(c)) begin
					len_n = sat_add(len_q, 2'd1);
				end else if (c == C_DOT) begin
					mode_n = stl_pkg::M_NUMDOT;
				end else begin
					av = 1'b1;
					ak = frac_q ? K_FLOAT : K_INT;
					mode_n = stl_pkg::M_IDLE;
					again = 1'b1;
				end
			end
			stl_pkg::M_NUMDOT: begin
				if (c == C_DOT) begin
					av = 1'b1;
					ak = frac_q ? K_FLOAT : K_INT;
					mode_n = stl_pkg::M_DOT2;
					tb_n = off_q - OB'(1);
					tbl_n = line_q;
					len_n = LB'(2);
				end else if (is_digit(c)) begin
					frac_n = 1'b1;
					len_n = sat_add(len_q, 2'd2);
					mode_n = stl_pkg::M_NUMBER;
				end else begin
					av = 1'b1;
					ak = K_FLOAT;
					al = sat_add(len_q, 2'd1);
					mode_n = stl_pkg::M_IDLE;
					again = 1'b1;
				end
			end
			stl_pkg::M_STRING: begin
				if (c == C_NUL) begin
					av = 1'b1;
					ak = K_BAD;
					mode_n = stl_pkg::M_IDLE;
					again = 1'b1;
				end else if (c == C_QUOTE && !bs_q) begin
					av = 1'b1;
					ak = K_STR;
					mode_n = stl_pkg::M_IDLE;
				end else begin
					len_n = sat_add(len_q, 2'd1);
					bs_n = c == C_BSL;
				end
			end
			stl_pkg::M_COMMENT: begin
				if (c == C_LF) begin
					line_n = line_q + LW'(1);
					mode_n = stl_pkg::M_IDLE;
				end else if (c == C_NUL) begin
					mode_n = stl_pkg::M_IDLE;
					again = 1'b1;
				end
			end
			stl_pkg::M_SLASH: begin
				mode_n = stl_pkg::M_IDLE;
				if (c == C_SLASH) begin
					mode_n = stl_pkg::M_COMMENT;
				end else if (c == C_EQ) begin
					av = 1'b1; ak = K_DIVEQ; al = LB'(2);
				end else begin
					av = 1'b1; ak = K_DIV; al = LB'(1);
					again = 1'b1;
				end
			end
			stl_pkg::M_DOT1: begin
				if (c == C_DOT) begin
					mode_n = stl_pkg::M_DOT2;
				end else begin
					av = 1'b1; ak = K_DOT; al = LB'(1);
					mode_n = stl_pkg::M_IDLE;
					again = 1'b1;
				end
			end
			stl_pkg::M_DOT2: begin
				mode_n = stl_pkg::M_IDLE;
				av = 1'b1;
				if (c == C_DOT) begin
					ak = K_DOT3; al = LB'(3);
				end else begin
					ak = K_DOT2; al = LB'(2);
					again = 1'b1;
				end
			end
			stl_pkg::M_OP1: begin
				mode_n = stl_pkg::M_IDLE;
				av = 1'b1;
				if (pk != K_END) begin
					ak = pk; al = LB'(2);
				end else begin
					ak = sk; al = LB'(1);
					again = 1'b1;
				end
			end
			default: begin
				mode_n = stl_pkg::M_IDLE;
				again = 1'b1;
			end
		endcase

		if (again) begin
			iln = line_n;
			unique case (c)
				C_NUL: begin
					iv = 1'b1; ik = K_END; il = '0; ended = 1'b1;
				end
				C_SP, C_TAB, C_CR: begin
				end
				C_LF: begin
					line_n = line_n + LW'(1);
				end
				C_QUOTE: begin
					mode_n = stl_pkg::M_STRING;
					tb_n = off_q + OB'(1); tbl_n = line_n; len_n = '0; bs_n = 1'b0;
				end
				C_SLASH: begin
					mode_n = stl_pkg::M_SLASH; tb_n = off_q; tbl_n = line_n; len_n = LB'(1);
				end
				C_DOT: begin
					mode_n = stl_pkg::M_DOT1; tb_n = off_q; tbl_n = line_n; len_n = LB'(1);
				end
				C_BAR, C_EQ, C_BANG, C_AMP, C_STAR, C_PLUS, C_MINUS, C_GT, C_LT: begin
					mode_n = stl_pkg::M_OP1; tb_n = off_q; tbl_n = line_n; len_n = LB'(1);
					h0_n = c; hc_n = 2'd1;
				end
				C_LBRACE: begin iv = 1'b1; ik = K_LBRACE; end
				C_RBRACE: begin iv = 1'b1; ik = K_RBRACE; end
				C_LBRACK: begin iv = 1'b1; ik = K_LBRACK; end
				C_RBRACK: begin iv = 1'b1; ik = K_RBRACK; end
				C_LPAREN: begin iv = 1'b1; ik = K_LPAREN; end
				C_RPAREN: begin iv = 1'b1; ik = K_RPAREN; end
				C_SEMI:   begin iv = 1'b1; ik = K_SEMI; end
				C_COLON:  begin iv = 1'b1; ik = K_COLON; end
				C_COMMA:  begin iv = 1'b1; ik = K_COMMA; end
				C_HASH:   begin iv = 1'b1; ik = K_HASH; end
				C_PCT:    begin iv = 1'b1; ik = K_MOD; end
				default: begin
					if (id_first(c)) begin
						mode_n = stl_pkg::M_IDENT; tb_n = off_q; tbl_n = line_n;
						len_n = LB'(1); h0_n = c; hc_n = 2'd1;
					end else if (is_digit(c)) begin
						mode_n = stl_pkg::M_NUMBER; tb_n = off_q; tbl_n = line_n;
						len_n = LB'(1); frac_n = 1'b0;
					end else begin
						iv = 1'b1; ik = K_BAD;
					end
				end
			endcase
		end

		off_n = off_q + OB'(1);
		if (ended) begin
			mode_n = stl_pkg::M_IDLE;
			h0_n = '0; h1_n = '0; hc_n = '0;
			off_n = '0; tb_n = '0; len_n = '0;
			line_n = start_q; tbl_n = start_q;
			frac_n = 1'b0; bs_n = 1'b0;
		end

		push0 = in_acc && (av || iv);
		push1 = in_acc && av && iv;
		if (av) begin
			res0 = {!iv, aln, al, ao, ak};
		end else begin
			res0 = {1'b1, iln, il, io, ik};
		end
		res1 = {1'b1, iln, il, io, ik};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stl_pkg::M_IDLE;
			h0_q <= '0; h1_q <= '0; hc_q <= '0;
			off_q <= '0; tb_q <= '0; len_q <= '0;
			line_q <= LW'(1); tbl_q <= LW'(1); start_q <= LW'(1);
			frac_q <= 1'b0; bs_q <= 1'b0;
		end else begin
			if (in_acc) begin
				mode_q <= mode_n;
				h0_q <= h0_n; h1_q <= h1_n; hc_q <= hc_n;
				off_q <= off_n; tb_q <= tb_n; len_q <= len_n;
				line_q <= line_n; tbl_q <= tbl_n;
				frac_q <= frac_n; bs_q <= bs_n;
			end
			if (cfg_we) begin
				start_q <= cfg_data;
				if (!in_acc && off_q == '0 && mode_q == stl_pkg::M_IDLE) begin
					line_q <= cfg_data;
					tbl_q <= cfg_data;
				end
			end
		end
	end

`ifndef SYNTH
	a_push_order: assert property (@(posedge clk) disable iff (!arst_n) push1 |-> push0)
		else $error("second word pushed without first");
	a_end_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && ended) |=> (off_q == '0 && mode_q == stl_pkg::M_IDLE))
		else $error("no restart after end word");
	a_len_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_acc && !cfg_we) |=> ($stable(off_q) && $stable(line_q)))
		else $error("state moved without a word");
`endif

endmodule

[sv/source_text_lexer.sv]
`timescale 1ns / 1ps

// Channel   Dir  Word
// s_*       in   tdata[7:0] text byte
// m_*       out  tuser token kind, tdata offset/length/line, tlast last of run
// cfg_*     in   start line, written when cfg_we is high
//
// Each byte is lexed in the cycle it is accepted; its tokens (none, one or two) enter
// a four-word output queue at the same edge, so one byte per cycle is taken while s_tready is high.
// s_tready is high while the queue has room for two words.
// Reset empties the queue, sets the start line to 1 and the lexer to idle.
// A stalled output only blocks input once the queue holds three words.

module source_text_lexer #(
	parameter int OFFSET_BITS = 32,
	parameter int LENGTH_BITS = 16,
	localparam int FW = OFFSET_BITS + LENGTH_BITS + stl_pkg::LINE_W,
	localparam int TDW = ((FW + 7) / 8) * 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // text_byte
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [TDW-1:0]             m_tdata,   // start_offset, token_length, line_number
	output logic [stl_pkg::KIND_W-1:0] m_tuser,   // token_kind
	output logic                       m_tlast,   // last_of_run
	input  logic                       cfg_we,
	input  logic [stl_pkg::LINE_W-1:0] cfg_data   // start_line
);

	localparam int RW = 1 + FW + stl_pkg::KIND_W;

	logic          in_acc, push0, push1, room2;
	logic [RW-1:0] res0, res1, head;

	assign in_acc = s_tvalid && s_tready;
	assign s_tready = room2;

	stl_core #(.OFFSET_BITS(OFFSET_BITS), .LENGTH_BITS(LENGTH_BITS)) u_core (
		.clk(clk), .arst_n(arst_n), .in_acc(in_acc), .in_byte(s_tdata),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.push0(push0), .push1(push1), .res0(res0), .res1(res1)
	);

	stl_outq #(.W(RW)) u_outq (
		.clk(clk), .arst_n(arst_n), .push0(push0), .push1(push1),
		.data0(res0), .data1(res1), .pop(m_tvalid && m_tready),
		.head(head), .not_empty(m_tvalid), .room2(room2)
	);

	assign m_tuser = head[stl_pkg::KIND_W-1:0];
	assign m_tdata = TDW'(head[RW-2:stl_pkg::KIND_W]);
	assign m_tlast = head[RW-1];

endmodule
